>>> src/frpm_pkg.sv
// Package for the letterbox point-to-source mapper.
// Holds register indexes, the fit selection code and the queue status type.
// No dependencies.
`timescale 1ns / 1ps

package frpm_pkg;

    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEWPORT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEWPORT_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIT_MODE        = 3'd4;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;

    // Which display axis is fitted to the viewport; the other axis is derived by division.
    typedef enum logic [1:0] {
        FIT_NONE = 2'd0,
        FIT_X    = 2'd1,
        FIT_Y    = 2'd2
    } fit_sel_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

>>> src/fit_rect_point_to_source_mapper.sv
// Top level of the letterbox point-to-source mapper.
// Depends on frpm_pkg, frpm_front, frpm_fifo and frpm_back.
//
// Usage: configuration is written through cfg_we/cfg_index/cfg_data while
// the block is idle. A point transfer is taken at each rising edge where
// start is high and busy is low. Each accepted point yields exactly one
// result: done pulses for one cycle with hit, src_x and src_y valid.
//
// Throughput is one point per cycle while busy is low. One multiply stage
// and a DIM_BITS-stage divider derive the display rectangle, the queue adds
// its count and output registers, and a multiply stage, a second DIM_BITS-stage
// divider pair and the output register scale the point back to source pixels.
//
// Reset clears all pipeline valids and sets the sizes to zero and fit mode
// to one, so results report no hit until sizes are written. The receiver
// cannot stall; the queue drains every cycle, so busy stays low in practice.
`timescale 1ns / 1ps

module fit_rect_point_to_source_mapper #(
    parameter int DIM_BITS = 13
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [DIM_BITS+1:0]             view_x,
    input  logic signed [DIM_BITS+1:0]             view_y,
    input  logic                                   cfg_we,
    input  logic [frpm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [DIM_BITS-1:0]                    cfg_data,
    output logic                                   done,
    output logic                                   hit,
    output logic [DIM_BITS-1:0]                    src_x,
    output logic [DIM_BITS-1:0]                    src_y
);

    localparam int EW = 4*DIM_BITS + 1;

    logic [DIM_BITS-1:0] sw_reg;
    logic [DIM_BITS-1:0] sh_reg;
    logic [DIM_BITS-1:0] vw_reg;
    logic [DIM_BITS-1:0] vh_reg;
    logic                fit_reg;

    // Register writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg  <= '0;
            sh_reg  <= '0;
            vw_reg  <= '0;
            vh_reg  <= '0;
            fit_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                frpm_pkg::REG_SOURCE_WIDTH:    sw_reg  <= cfg_data;
                frpm_pkg::REG_SOURCE_HEIGHT:   sh_reg  <= cfg_data;
                frpm_pkg::REG_VIEWPORT_WIDTH:  vw_reg  <= cfg_data;
                frpm_pkg::REG_VIEWPORT_HEIGHT: vh_reg  <= cfg_data;
                frpm_pkg::REG_FIT_MODE:        fit_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    logic                 accept;
    logic                 push;
    logic [EW-1:0]        entry_in;
    logic                 q_valid;
    logic [EW-1:0]        entry_out;
    frpm_pkg::fifo_stat_t q_stat;

    assign busy   = q_stat.full;
    assign accept = start && !busy;

    frpm_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .view_x          (view_x),
        .view_y          (view_y),
        .source_width    (sw_reg),
        .source_height   (sh_reg),
        .viewport_width  (vw_reg),
        .viewport_height (vh_reg),
        .fit_en          (fit_reg),
        .push            (push),
        .entry           (entry_in)
    );

    frpm_fifo #(
        .WIDTH (EW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (entry_in),
        .out_valid (q_valid),
        .dout      (entry_out),
        .stat      (q_stat)
    );

    frpm_back #(
        .DIM_BITS (DIM_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (q_valid),
        .entry         (entry_out),
        .source_width  (sw_reg),
        .source_height (sh_reg),
        .done          (done),
        .hit           (hit),
        .src_x         (src_x),
        .src_y         (src_y)
    );

endmodule

>>> src/frpm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Carries a payload alongside each transfer. Uses no package items.
`timescale 1ns / 1ps

module frpm_div #(
    parameter int DW = 28,
    parameter int VW = 14,
    parameter int QW = 13,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_dividend,
    input  logic [VW-1:0] in_divisor,
    input  logic [PW-1:0] in_payload,
    output logic          out_valid,
    output logic [QW-1:0] out_quotient,
    output logic [PW-1:0] out_payload
);

    logic          vld_reg [QW];
    logic [DW-1:0] rem_reg [QW];
    logic [VW-1:0] dvs_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [PW-1:0] pay_reg [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            localparam int B = QW - 1 - k;
            logic          vld_in;
            logic [DW-1:0] rem_in;
            logic [VW-1:0] dvs_in;
            logic [QW-1:0] quo_in;
            logic [PW-1:0] pay_in;
            logic [DW-1:0] shifted;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign vld_in = in_valid;
                assign rem_in = in_dividend;
                assign dvs_in = in_divisor;
                assign quo_in = '0;
                assign pay_in = in_payload;
            end
            else
            begin : g_next
                assign vld_in = vld_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign dvs_in = dvs_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign pay_in = pay_reg[k-1];
            end

            assign shifted = {{(DW-VW){1'b0}}, dvs_in} << B;
            assign ge      = (rem_in >= shifted);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= ge ? (rem_in - shifted) : rem_in;
                dvs_reg[k] <= dvs_in;
                quo_reg[k] <= quo_in | ({{(QW-1){1'b0}}, ge} << B);
                pay_reg[k] <= pay_in;
            end
        end
    endgenerate

    assign out_valid    = vld_reg[QW-1];
    assign out_quotient = quo_reg[QW-1];
    assign out_payload  = pay_reg[QW-1];

endmodule

>>> src/frpm_fifo.sv
// Small queue between the classifying front and the mapping back.
// Depends on frpm_pkg for depth and status type.
`timescale 1ns / 1ps

module frpm_fifo #(
    parameter int WIDTH = 53
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    din,
    output logic                out_valid,
    output logic [WIDTH-1:0]    dout,
    output frpm_pkg::fifo_stat_t stat
);

    localparam int PB = frpm_pkg::FIFO_PTR_BITS;

    logic [WIDTH-1:0] mem [frpm_pkg::FIFO_DEPTH];
    logic [PB-1:0]    wptr_reg;
    logic [PB-1:0]    rptr_reg;
    logic [PB:0]      count_reg;
    logic [PB:0]      count_next;
    logic             valid_reg;
    logic [WIDTH-1:0] dout_reg;
    logic             pop;

    // The back side never stalls, so any stored entry leaves at once.
    assign pop        = (count_reg != '0);
    assign count_next = count_reg + {{PB{1'b0}}, push} - {{PB{1'b0}}, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
            valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= din;
        end
        dout_reg <= mem[rptr_reg];
    end

    assign out_valid  = valid_reg;
    assign dout       = dout_reg;
    assign stat.full  = (count_reg == (PB+1)'(frpm_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

>>> src/frpm_front.sv
// Front part: accepts points, derives the display rectangle and classifies hits.
// Depends on frpm_pkg and frpm_div.
`timescale 1ns / 1ps

module frpm_front #(
    parameter int DIM_BITS = 13
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic signed [DIM_BITS+1:0] view_x,
    input  logic signed [DIM_BITS+1:0] view_y,
    input  logic [DIM_BITS-1:0]        source_width,
    input  logic [DIM_BITS-1:0]        source_height,
    input  logic [DIM_BITS-1:0]        viewport_width,
    input  logic [DIM_BITS-1:0]        viewport_height,
    input  logic                       fit_en,
    output logic                       push,
    output logic [4*DIM_BITS:0]        entry
);

    localparam int D  = DIM_BITS;
    localparam int DW = 2*D + 2;
    localparam int PW = 2 + 2*(D + 2);

    logic                 v1_reg;
    logic signed [D+1:0]  px1_reg;
    logic signed [D+1:0]  py1_reg;
    logic [2*D-1:0]       pa_reg;
    logic [2*D-1:0]       pb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    // vw*sh and vh*sw serve both the axis choice and the divider numerator.
    always_ff @(posedge clk)
    begin
        px1_reg <= view_x;
        py1_reg <= view_y;
        pa_reg  <= {{D{1'b0}}, viewport_width} * {{D{1'b0}}, source_height};
        pb_reg  <= {{D{1'b0}}, viewport_height} * {{D{1'b0}}, source_width};
    end

    frpm_pkg::fit_sel_t sel;
    logic [DW-1:0]      dvd;
    logic [D:0]         dvs;

    always_comb
    begin
        sel = frpm_pkg::FIT_NONE;
        dvd = '0;
        dvs = '0;
        if (fit_en)
        begin
            if (pa_reg <= pb_reg)
            begin
                if (viewport_width < source_width)
                begin
                    sel = frpm_pkg::FIT_X;
                    dvd = {1'b0, pa_reg, 1'b0} + {{(D+2){1'b0}}, source_width};
                    dvs = {source_width, 1'b0};
                end
            end
            else if (viewport_height < source_height)
            begin
                sel = frpm_pkg::FIT_Y;
                dvd = {1'b0, pb_reg, 1'b0} + {{(D+2){1'b0}}, source_height};
                dvs = {source_height, 1'b0};
            end
        end
    end

    logic          dv_valid;
    logic [D-1:0]  dv_q;
    logic [PW-1:0] dv_pay;

    frpm_div #(
        .DW (DW),
        .VW (D + 1),
        .QW (D),
        .PW (PW)
    ) u_geom_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (v1_reg),
        .in_dividend  (dvd),
        .in_divisor   (dvs),
        .in_payload   ({sel, px1_reg, py1_reg}),
        .out_valid    (dv_valid),
        .out_quotient (dv_q),
        .out_payload  (dv_pay)
    );

    frpm_pkg::fit_sel_t  sel_o;
    logic signed [D+1:0] px_o;
    logic signed [D+1:0] py_o;
    logic [D-1:0]        tw;
    logic [D-1:0]        th;
    logic signed [D:0]   dx;
    logic signed [D:0]   dy;
    logic signed [D:0]   left;
    logic signed [D:0]   top;
    logic signed [D+2:0] rx;
    logic signed [D+2:0] ry;
    logic                sizes_ok;
    logic                in_rect;

    assign sel_o = frpm_pkg::fit_sel_t'(dv_pay[PW-1 -: 2]);
    assign px_o  = dv_pay[2*(D+2)-1 -: D+2];
    assign py_o  = dv_pay[D+1:0];

    always_comb
    begin
        case (sel_o)
            frpm_pkg::FIT_X:
            begin
                tw = viewport_width;
                th = dv_q;
            end
            frpm_pkg::FIT_Y:
            begin
                tw = dv_q;
                th = viewport_height;
            end
            default:
            begin
                tw = source_width;
                th = source_height;
            end
        endcase
    end

    // Offsets are halved with truncation toward zero.
    assign dx   = $signed({1'b0, viewport_width}) - $signed({1'b0, tw});
    assign dy   = $signed({1'b0, viewport_height}) - $signed({1'b0, th});
    assign left = (dx + $signed({{D{1'b0}}, dx[D]})) >>> 1;
    assign top  = (dy + $signed({{D{1'b0}}, dy[D]})) >>> 1;
    assign rx   = $signed({px_o[D+1], px_o}) - $signed({{2{left[D]}}, left});
    assign ry   = $signed({py_o[D+1], py_o}) - $signed({{2{top[D]}}, top});

    assign sizes_ok = (source_width != '0) && (source_height != '0) &&
                      (viewport_width != '0) && (viewport_height != '0) &&
                      (tw != '0) && (th != '0);
    assign in_rect  = !rx[D+2] && !ry[D+2] &&
                      ($unsigned(rx) < {3'b000, tw}) && ($unsigned(ry) < {3'b000, th});

    assign push  = dv_valid;
    assign entry = {sizes_ok && in_rect, rx[D-1:0], ry[D-1:0], tw, th};

endmodule

>>> src/frpm_back.sv
// Back part: scales the in-rectangle offset back to source coordinates.
// Depends on frpm_div.
`timescale 1ns / 1ps

module frpm_back #(
    parameter int DIM_BITS = 13
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [4*DIM_BITS:0] entry,
    input  logic [DIM_BITS-1:0] source_width,
    input  logic [DIM_BITS-1:0] source_height,
    output logic                done,
    output logic                hit,
    output logic [DIM_BITS-1:0] src_x,
    output logic [DIM_BITS-1:0] src_y
);

    localparam int D  = DIM_BITS;
    localparam int DW = 2*D + 2;

    logic         e_hit;
    logic [D-1:0] e_rx;
    logic [D-1:0] e_ry;
    logic [D-1:0] e_tw;
    logic [D-1:0] e_th;
    logic [D-1:0] smx;
    logic [D-1:0] smy;

    assign e_hit = entry[4*D];
    assign e_rx  = entry[4*D-1 -: D];
    assign e_ry  = entry[3*D-1 -: D];
    assign e_tw  = entry[2*D-1 -: D];
    assign e_th  = entry[D-1:0];
    assign smx   = source_width - 1'b1;
    assign smy   = source_height - 1'b1;

    logic           v1_reg;
    logic           hit1_reg;
    logic [2*D-1:0] prx_reg;
    logic [2*D-1:0] pry_reg;
    logic [D-1:0]   dmx_reg;
    logic [D-1:0]   dmy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit1_reg <= e_hit;
        prx_reg  <= {{D{1'b0}}, e_rx} * {{D{1'b0}}, smx};
        pry_reg  <= {{D{1'b0}}, e_ry} * {{D{1'b0}}, smy};
        dmx_reg  <= (e_tw > {{(D-1){1'b0}}, 1'b1}) ? (e_tw - 1'b1) : {{(D-1){1'b0}}, 1'b1};
        dmy_reg  <= (e_th > {{(D-1){1'b0}}, 1'b1}) ? (e_th - 1'b1) : {{(D-1){1'b0}}, 1'b1};
    end

    logic         qx_valid;
    logic         qy_valid;
    logic [D-1:0] qx;
    logic [D-1:0] qy;
    logic         hx;
    logic         hy;

    frpm_div #(
        .DW (DW),
        .VW (D + 1),
        .QW (D),
        .PW (1)
    ) u_div_x (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (v1_reg),
        .in_dividend  ({1'b0, prx_reg, 1'b0} + {{(D+2){1'b0}}, dmx_reg}),
        .in_divisor   ({dmx_reg, 1'b0}),
        .in_payload   (hit1_reg),
        .out_valid    (qx_valid),
        .out_quotient (qx),
        .out_payload  (hx)
    );

    frpm_div #(
        .DW (DW),
        .VW (D + 1),
        .QW (D),
        .PW (1)
    ) u_div_y (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (v1_reg),
        .in_dividend  ({1'b0, pry_reg, 1'b0} + {{(D+2){1'b0}}, dmy_reg}),
        .in_divisor   ({dmy_reg, 1'b0}),
        .in_payload   (hit1_reg),
        .out_valid    (qy_valid),
        .out_quotient (qy),
        .out_payload  (hy)
    );

    logic         done_reg;
    logic         hit_reg;
    logic [D-1:0] sx_reg;
    logic [D-1:0] sy_reg;
    logic         hit_o;

    assign hit_o = hx && hy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= qx_valid && qy_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_o;
        sx_reg  <= !hit_o ? '0 : ((qx > smx) ? smx : qx);
        sy_reg  <= !hit_o ? '0 : ((qy > smy) ? smy : qy);
    end

    assign done  = done_reg;
    assign hit   = hit_reg;
    assign src_x = sx_reg;
    assign src_y = sy_reg;

endmodule
